/* src/cconv_pkg.sv */
// shared constants, payload types and divider interface types for the 5x5 convolution unit
package cconv_pkg;

    // frame geometry
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int ADDR_BITS   = COL_BITS + ROW_BITS;
    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    // field and register widths
    localparam int COORD_BITS    = 8;
    localparam int PIX_BITS      = 8;
    localparam int DIM_BITS      = 9;
    localparam int POS_BITS      = DIM_BITS + 2;
    localparam int KSIZE         = 5;
    localparam int KHALF         = 2;
    localparam int TAP_BITS      = $clog2(KSIZE);
    localparam int COEF_BITS     = 8;
    localparam int KROW_BITS     = KSIZE * COEF_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = KROW_BITS;
    localparam int PIX_MAX       = 255;

    // arithmetic widths: 25 taps of 8-bit signed by 8-bit unsigned
    localparam int PROD_BITS = COEF_BITS + PIX_BITS + 1;
    localparam int ACC_BITS  = 21;
    localparam int AMT_BITS  = 13;
    localparam int QMAG_BITS = ACC_BITS - 1;
    localparam int DMAG_BITS = AMT_BITS - 1;
    localparam int STEP_BITS = $clog2(QMAG_BITS + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_KROW0  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_KROW1  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_KROW2  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_KROW3  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_KROW4  = 3'd6;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_READ  = 1'b1
    } func_t;

    typedef struct packed {
        func_t                 func;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [PIX_BITS-1:0]   pixel;
    } item_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] filtered;
        logic                out_of_range;
    } result_t;

    // divider request and response
    typedef struct packed {
        logic                       start;
        logic signed [ACC_BITS-1:0] num;
        logic signed [AMT_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [ACC_BITS-1:0] quot;
    } div_resp_t;

endpackage

/* src/cconv_div.sv */
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module cconv_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cconv_pkg::div_req_t  req,
    output cconv_pkg::div_resp_t resp
);
    import cconv_pkg::*;

    logic                        busy_reg;
    logic                        done_reg;
    logic [STEP_BITS-1:0]        step_reg;
    logic [DMAG_BITS-1:0]        rem_reg;
    logic [QMAG_BITS-1:0]        quo_reg;
    logic [DMAG_BITS-1:0]        den_reg;
    logic                        neg_reg;
    logic signed [ACC_BITS-1:0]  num_abs;
    logic signed [AMT_BITS-1:0]  den_abs;
    logic [DMAG_BITS:0]          rem_shift;
    logic [DMAG_BITS:0]          rem_diff;
    logic                        fits;

    // operand magnitudes
    assign num_abs = req.num[ACC_BITS-1] ? -req.num : req.num;
    assign den_abs = req.den[AMT_BITS-1] ? -req.den : req.den;

    // restoring step
    assign rem_shift = {rem_reg, quo_reg[QMAG_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fits      = rem_shift >= {1'b0, den_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_BITS'(QMAG_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= num_abs[QMAG_BITS-1:0];
            den_reg <= den_abs[DMAG_BITS-1:0];
            rem_reg <= '0;
            neg_reg <= req.num[ACC_BITS-1] ^ req.den[AMT_BITS-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_diff[DMAG_BITS-1:0] : rem_shift[DMAG_BITS-1:0];
            quo_reg <= {quo_reg[QMAG_BITS-2:0], fits};
        end
    end

    // signed quotient
    assign resp.done = done_reg;
    assign resp.quot = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

/* src/clamped_5x5_convolution_unit.sv */
// 5x5 convolution over a stored gray frame with edge clamping, division and saturation
// Writes and out-of-range items pass from S_DECODE straight to S_RESULT; reads step through
// S_CONV over the 25 taps, S_DRAIN and S_KSUM, and S_DIV as well when the coefficient sum is nonzero.
// Throughput: the next item is taken in the cycle after the result is loaded into the output register;
// the 25 frame reads through the single read port and the 20-step bit-serial divider set the read pace.
// Reset: asynchronous active low; dimensions return to 256x256, kernel to all zero,
// the frame store is not cleared and holds undefined data until written.
module clamped_5x5_convolution_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  cconv_pkg::item_t                      item,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output cconv_pkg::result_t                    result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cconv_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [cconv_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import cconv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CONV,
        S_DRAIN,
        S_KSUM,
        S_DIV,
        S_RESULT
    } state_t;

    state_t                      state_reg;
    item_t                       item_reg;
    logic [DIM_BITS-1:0]         width_reg;
    logic [DIM_BITS-1:0]         height_reg;
    logic [KROW_BITS-1:0]        kernel_reg [KSIZE];
    logic [TAP_BITS-1:0]         tap_i_reg;
    logic [TAP_BITS-1:0]         tap_j_reg;
    logic                        mac_vld_reg;
    logic signed [COEF_BITS-1:0] coef_d_reg;
    logic [PIX_BITS-1:0]         rd_data_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;
    logic signed [AMT_BITS-1:0]  amount_reg;
    logic [PIX_BITS-1:0]         res_val_reg;
    logic                        res_oor_reg;
    logic                        result_valid_reg;
    result_t                     result_reg;
    logic [PIX_BITS-1:0]         frame_mem [FRAME_DEPTH];

    logic [DIM_BITS-1:0]         width_eff;
    logic [DIM_BITS-1:0]         height_eff;
    logic                        oor;
    logic                        mem_we;
    logic [ADDR_BITS-1:0]        wr_addr;
    logic [ADDR_BITS-1:0]        rd_addr;
    logic [DIM_BITS-1:0]         x_sel;
    logic [DIM_BITS-1:0]         y_sel;
    logic signed [COEF_BITS-1:0] coef_sel;
    logic signed [PROD_BITS-1:0] prod;
    logic                        res_load;
    div_req_t                    div_req;
    div_resp_t                   div_resp;

    // clamp a neighbour coordinate to 0..lim
    function automatic logic [DIM_BITS-1:0] clamp_pos(
        input logic [COORD_BITS-1:0] c,
        input logic [TAP_BITS-1:0]   k,
        input logic [DIM_BITS-1:0]   lim
    );
        logic [POS_BITS-1:0] pos;
        pos = POS_BITS'(c) + POS_BITS'(k) - POS_BITS'(KHALF);
        if (pos[POS_BITS-1])
            return '0;
        else if (pos[DIM_BITS:0] > {1'b0, lim})
            return lim;
        else
            return pos[DIM_BITS-1:0];
    endfunction

    // saturate to the pixel range
    function automatic logic [PIX_BITS-1:0] sat_pix(input logic signed [ACC_BITS-1:0] v);
        if (v < 0)
            return '0;
        else if (v > $signed(ACC_BITS'(PIX_MAX)))
            return PIX_BITS'(PIX_MAX);
        else
            return v[PIX_BITS-1:0];
    endfunction

    // effective image size
    always_comb
    begin
        if (width_reg == '0)
            width_eff = DIM_BITS'(1);
        else if (width_reg > DIM_BITS'(MAX_WIDTH))
            width_eff = DIM_BITS'(MAX_WIDTH);
        else
            width_eff = width_reg;
        if (height_reg == '0)
            height_eff = DIM_BITS'(1);
        else if (height_reg > DIM_BITS'(MAX_HEIGHT))
            height_eff = DIM_BITS'(MAX_HEIGHT);
        else
            height_eff = height_reg;
    end

    assign oor = (DIM_BITS'(item_reg.col) >= width_eff) ||
                 (DIM_BITS'(item_reg.row) >= height_eff);

    // handshakes
    assign item_stall   = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign res_load     = (state_reg == S_RESULT) && (!result_valid_reg || !result_stall);

    // frame addressing and tap selection
    assign x_sel    = clamp_pos(item_reg.col, tap_i_reg, width_eff - 1'b1);
    assign y_sel    = clamp_pos(item_reg.row, tap_j_reg, height_eff - 1'b1);
    assign rd_addr  = {y_sel[ROW_BITS-1:0], x_sel[COL_BITS-1:0]};
    assign wr_addr  = {ROW_BITS'(item_reg.row), COL_BITS'(item_reg.col)};
    assign mem_we   = (state_reg == S_DECODE) && !oor && (item_reg.func == FUNC_WRITE);
    assign coef_sel = $signed(kernel_reg[tap_j_reg][COEF_BITS*tap_i_reg +: COEF_BITS]);
    assign prod     = coef_d_reg * $signed({1'b0, rd_data_reg});

    // frame store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[wr_addr] <= item_reg.pixel;
        rd_data_reg <= frame_mem[rd_addr];
    end

    // divider for the kernel-sum normalization
    assign div_req.start = (state_reg == S_KSUM) && (amount_reg != '0);
    assign div_req.num   = acc_reg;
    assign div_req.den   = amount_reg;

    cconv_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .resp (div_resp)
    );

    // sequencer, configuration and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tap_i_reg        <= '0;
            tap_j_reg        <= '0;
            mac_vld_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            width_reg        <= DIM_BITS'(256);
            height_reg       <= DIM_BITS'(256);
            for (int k = 0; k < KSIZE; k++)
                kernel_reg[k] <= '0;
        end
        else
        begin
            // configuration transaction
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_WIDTH:  width_reg     <= cfg_data[DIM_BITS-1:0];
                    REG_HEIGHT: height_reg    <= cfg_data[DIM_BITS-1:0];
                    REG_KROW0:  kernel_reg[0] <= cfg_data;
                    REG_KROW1:  kernel_reg[1] <= cfg_data;
                    REG_KROW2:  kernel_reg[2] <= cfg_data;
                    REG_KROW3:  kernel_reg[3] <= cfg_data;
                    REG_KROW4:  kernel_reg[4] <= cfg_data;
                    default:    ;
                endcase
            end

            // output register fills from the sequencer and drains on acceptance
            if (res_load)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;

            mac_vld_reg <= (state_reg == S_CONV);

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                        state_reg <= S_DECODE;
                end
                S_DECODE:
                begin
                    tap_i_reg <= '0;
                    tap_j_reg <= '0;
                    if (oor || item_reg.func == FUNC_WRITE)
                        state_reg <= S_RESULT;
                    else
                        state_reg <= S_CONV;
                end
                S_CONV:
                begin
                    if (tap_i_reg == TAP_BITS'(KSIZE - 1))
                    begin
                        tap_i_reg <= '0;
                        if (tap_j_reg == TAP_BITS'(KSIZE - 1))
                            state_reg <= S_DRAIN;
                        else
                            tap_j_reg <= tap_j_reg + 1'b1;
                    end
                    else
                    begin
                        tap_i_reg <= tap_i_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_KSUM;
                end
                S_KSUM:
                begin
                    if (amount_reg == '0)
                        state_reg <= S_RESULT;
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_resp.done)
                        state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (res_load)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // item capture, multiply-accumulate and result payload
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            item_reg <= item;

        coef_d_reg <= coef_sel;

        if (state_reg == S_DECODE)
        begin
            acc_reg     <= '0;
            amount_reg  <= '0;
            res_val_reg <= '0;
            res_oor_reg <= oor;
        end
        else
        begin
            if (mac_vld_reg)
                acc_reg <= acc_reg + ACC_BITS'(prod);
            if (state_reg == S_CONV)
                amount_reg <= amount_reg + AMT_BITS'(coef_sel);
        end

        if (state_reg == S_KSUM && amount_reg == '0)
            res_val_reg <= sat_pix(acc_reg);
        if (state_reg == S_DIV && div_resp.done)
            res_val_reg <= sat_pix(div_resp.quot);

        if (res_load)
        begin
            result_reg.filtered     <= res_val_reg;
            result_reg.out_of_range <= res_oor_reg;
        end
    end

`ifndef NO_ASSERTIONS
    // the last product is still in flight when the tap loop ends
    a_drain_has_product: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN |-> mac_vld_reg)
        else $error("drain cycle without a pending product");

    // the divider is never started on a zero coefficient sum
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> amount_reg != '0)
        else $error("divider started with zero divisor");

    // a quotient only arrives while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_resp.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    // tap counters stay inside the kernel
    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CONV |-> (tap_i_reg < TAP_BITS'(KSIZE)) && (tap_j_reg < TAP_BITS'(KSIZE)))
        else $error("tap counter beyond kernel size");
`endif

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the clamped 5x5 convolution unit
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cconv_pkg::*;

    localparam int ITEM_TARGET    = 1800;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

    typedef enum int {
        KERN_ZERO,
        KERN_MOST_NEG,
        KERN_MOST_POS,
        KERN_RANDOM,
        KERN_ZERO_SUM,
        KERN_BLUR,
        KERN_LOG
    } kernel_kind_t;

    // mirror of the frame and registers, plus the queue of awaited pixels
    class filter_scoreboard;
        localparam int MAX_REPORTS = 10;

        bit [PIX_BITS-1:0]  frame [FRAME_DEPTH];
        bit [DIM_BITS-1:0]  width_reg;
        bit [DIM_BITS-1:0]  height_reg;
        bit [KROW_BITS-1:0] kernel [KSIZE];
        result_t            awaited_pixels [$];
        int                 mismatches;

        function new();
            width_reg  = DIM_BITS'(MAX_WIDTH);
            height_reg = DIM_BITS'(MAX_HEIGHT);
            mismatches = 0;
        endfunction

        static function int clamp(int v, int lo, int hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        // a size of zero acts as one, oversize saturates
        function int cols_in_use();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return int'(width_reg);
        endfunction

        function int rows_in_use();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return int'(height_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_WIDTH:  width_reg = data[DIM_BITS-1:0];
                REG_HEIGHT: height_reg = data[DIM_BITS-1:0];
                REG_KROW0:  kernel[0] = data;
                REG_KROW1:  kernel[1] = data;
                REG_KROW2:  kernel[2] = data;
                REG_KROW3:  kernel[3] = data;
                REG_KROW4:  kernel[4] = data;
                default:    ;
            endcase
        endfunction

        // reads: clamped weighted sum divided by the coefficient sum, saturated
        function result_t filter_pixel(item_t it);
            result_t r;
            int      w;
            int      h;
            int      acc;
            int      amount;
            int      c;
            int      x;
            int      y;
            r = '0;
            w = cols_in_use();
            h = rows_in_use();
            if (int'(it.col) >= w || int'(it.row) >= h) begin
                r.out_of_range = 1'b1;
                return r;
            end
            if (it.func == FUNC_WRITE) begin
                frame[int'(it.row) * MAX_WIDTH + int'(it.col)] = it.pixel;
                return r;
            end
            acc = 0;
            amount = 0;
            for (int j = 0; j < KSIZE; j++) begin
                y = clamp(int'(it.row) + j - KHALF, 0, h - 1);
                for (int i = 0; i < KSIZE; i++) begin
                    x = clamp(int'(it.col) + i - KHALF, 0, w - 1);
                    c = int'($signed(kernel[j][COEF_BITS*i +: COEF_BITS]));
                    acc += c * int'(frame[y * MAX_WIDTH + x]);
                    amount += c;
                end
            end
            if (amount != 0) acc = acc / amount;
            r.filtered = PIX_BITS'(clamp(acc, 0, PIX_MAX));
            return r;
        endfunction

        function void note_item(item_t it);
            awaited_pixels.push_back(filter_pixel(it));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: filtered=%0d out_of_range=%0b",
                             got.filtered, got.out_of_range);
                return;
            end
            want = awaited_pixels.pop_front();
            if (got.filtered !== want.filtered || got.out_of_range !== want.out_of_range) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: filtered exp %0d got %0d, out_of_range exp %0b got %0b",
                             want.filtered, got.filtered, want.out_of_range, got.out_of_range);
            end
        endfunction

        function int outstanding();
            return awaited_pixels.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     item_valid = 1'b0;
    logic                     item_stall;
    item_t                    item = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    result_t                  result;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    filter_scoreboard sb = new();

    bit pix_written [FRAME_DEPTH];
    int coefs [KSIZE][KSIZE];
    int burst_left = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int stall_mode = 0;
    int mode_cycles = 0;
    int stall_hold = 0;
    bit stall_on = 1'b0;

    clamped_5x5_convolution_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // note every accepted input transaction
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall) sb.note_item(item);
    end

    // check results and drive the receiver stall pattern
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall) sb.check_result(result);
        if (mode_cycles == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_cycles = $urandom_range(50, 400);
        end
        else begin
            mode_cycles--;
        end
        case (stall_mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 1) == 1);
            2: result_stall <= ($urandom_range(0, 7) == 0);
            default:
            begin
                if (stall_hold > 0) begin
                    stall_hold--;
                end
                else begin
                    stall_on = !stall_on;
                    stall_hold = stall_on ? $urandom_range(5, 30) : $urandom_range(1, 20);
                end
                result_stall <= stall_on;
            end
        endcase
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end
        else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // send one item, in bursts separated by random gaps
    task automatic push_item(input item_t it);
        if (burst_left == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (item_stall);
        items_sent++;
    endtask

    // hold off the sender until every awaited pixel has come back
    task automatic drain_results();
        item_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.outstanding() != 0);
    endtask

    task automatic write_pixel(input int col, input int row, input int pix);
        item_t it;
        if (col < sb.cols_in_use() && row < sb.rows_in_use())
            pix_written[row * MAX_WIDTH + col] = 1'b1;
        it.func = FUNC_WRITE;
        it.col = COORD_BITS'(col);
        it.row = COORD_BITS'(row);
        it.pixel = PIX_BITS'(pix);
        push_item(it);
    endtask

    // fill any neighbor not yet written, then ask for the filtered pixel
    task automatic read_filtered(input int col, input int row);
        item_t it;
        int    x;
        int    y;
        if (col < sb.cols_in_use() && row < sb.rows_in_use()) begin
            for (int j = 0; j < KSIZE; j++) begin
                for (int i = 0; i < KSIZE; i++) begin
                    y = filter_scoreboard::clamp(row + j - KHALF, 0, sb.rows_in_use() - 1);
                    x = filter_scoreboard::clamp(col + i - KHALF, 0, sb.cols_in_use() - 1);
                    if (!pix_written[y * MAX_WIDTH + x])
                        write_pixel(x, y, $urandom_range(0, 255));
                end
            end
        end
        it.func = FUNC_READ;
        it.col = COORD_BITS'(col);
        it.row = COORD_BITS'(row);
        it.pixel = PIX_BITS'($urandom_range(0, 255));
        push_item(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // idle the block, then load size and the kernel held in coefs
    task automatic configure(input int w, input int h);
        logic [CFG_DATA_BITS-1:0] krow;
        logic [CFG_DATA_BITS-1:0] filler;
        drain_results();
        repeat (4) @(posedge clk);
        filler = CFG_DATA_BITS'({$urandom, $urandom});
        if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, filler);
        write_reg(REG_WIDTH, {filler[CFG_DATA_BITS-1:DIM_BITS], DIM_BITS'(w)});
        write_reg(REG_HEIGHT, {~filler[CFG_DATA_BITS-1:DIM_BITS], DIM_BITS'(h)});
        for (int j = 0; j < KSIZE; j++) begin
            for (int i = 0; i < KSIZE; i++)
                krow[COEF_BITS*i +: COEF_BITS] = COEF_BITS'(coefs[j][i]);
            write_reg(CFG_IDX_BITS'(REG_KROW0 + j), krow);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_kernel(input kernel_kind_t kind);
        int total;
        int ring;
        total = 0;
        for (int j = 0; j < KSIZE; j++) begin
            for (int i = 0; i < KSIZE; i++) begin
                ring = (j > KHALF ? j - KHALF : KHALF - j) + (i > KHALF ? i - KHALF : KHALF - i);
                case (kind)
                    KERN_ZERO:     coefs[j][i] = 0;
                    KERN_MOST_NEG: coefs[j][i] = -128;
                    KERN_MOST_POS: coefs[j][i] = 127;
                    KERN_RANDOM:   coefs[j][i] = $urandom_range(0, 255);
                    KERN_BLUR:     coefs[j][i] = $urandom_range(0, 15);
                    KERN_ZERO_SUM: coefs[j][i] = int'($urandom_range(0, 10)) - 5;
                    default:       coefs[j][i] = (ring == 0) ? 16 : (ring == 1) ? -2
                                                 : (ring == 2) ? -1 : 0;
                endcase
                total += coefs[j][i];
            end
        end
        // balance the center so the coefficients cancel
        if (kind == KERN_ZERO_SUM) coefs[KHALF][KHALF] -= total;
    endtask

    // mostly small frames, with degenerate and oversize values now and then
    function automatic int pick_dim();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3, 4, 5, 6: return $urandom_range(3, 16);
            7:       return $urandom_range(17, 64);
            8:       return $urandom_range(1, 256);
            9:       return 256;
            10:      return $urandom_range(257, 511);
            default: return 511;
        endcase
    endfunction

    // uniform, edge-hugging, near the last coordinate, or anywhere in the field
    function automatic int pick_coord(int limit, int last);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom_range(0, limit - 1);
            5, 6: v = ($urandom_range(0, 1) == 1) ? limit - 1 - int'($urandom_range(0, 1))
                                                   : int'($urandom_range(0, 1));
            7, 8: v = last + int'($urandom_range(0, 6)) - 3;
            default: return $urandom_range(0, 255);
        endcase
        return filter_scoreboard::clamp(v, 0, limit - 1);
    endfunction

    // stimulus
    initial
    begin
        int w;
        int h;
        int c;
        int r;
        int kind;
        int phase_len;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // small frame with the log kernel: pixel extremes, corners, outside items
        pick_kernel(KERN_LOG);
        configure(4, 3);
        for (r = 0; r < 3; r++)
            for (c = 0; c < 4; c++)
                write_pixel(c, r, ((c + r) % 2 == 1) ? 255 : 0);
        read_filtered(0, 0);
        read_filtered(3, 2);
        read_filtered(1, 1);
        write_pixel(4, 0, 255);
        read_filtered(0, 3);
        write_pixel(255, 255, 170);
        read_filtered(255, 0);

        // zero width acts as one column, oversize height saturates, negative divisor
        pick_kernel(KERN_MOST_NEG);
        configure(0, 511);
        read_filtered(0, 2);
        read_filtered(0, 255);
        write_pixel(1, 0, 85);

        // random phases, each with its own frame size and kernel
        while (items_sent < ITEM_TARGET) begin
            pick_kernel(kernel_kind_t'($urandom_range(0, 6)));
            configure(pick_dim(), pick_dim());
            w = sb.cols_in_use();
            h = sb.rows_in_use();
            phase_len = $urandom_range(40, 160);
            for (int n = 0; n < phase_len && items_sent < ITEM_TARGET; n++) begin
                if ($urandom_range(0, 149) == 0) drain_results();
                c = pick_coord(w, c);
                r = pick_coord(h, r);
                kind = $urandom_range(0, 99);
                if (kind >= 90) begin
                    if (w < MAX_WIDTH && $urandom_range(0, 1) == 1) c = $urandom_range(w, 255);
                    else if (h < MAX_HEIGHT) r = $urandom_range(h, 255);
                end
                if (kind < 45 || (kind >= 90 && kind < 95))
                    write_pixel(c, r, $urandom_range(0, 255));
                else
                    read_filtered(c, r);
            end
        end

        // let everything come back, then give the verdict
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
src/cconv_pkg.sv
src/cconv_div.sv
src/clamped_5x5_convolution_unit.sv
tb/tb_top.sv
